// ===== hw/rtl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the RTC peripheral
// Register offsets, field widths, operation codes and payload structs.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Width of the day counter and of the alarm day register (8 to 32)
  localparam int unsigned DAY_BITS = 16;

  localparam int unsigned HOUR_BITS = 5;
  localparam int unsigned SIX_BITS  = 6;

  // Operation codes; code 3 is unused and has no effect
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register byte offsets
  localparam logic [6:0] ADDR_CTRL      = 7'h00;
  localparam logic [6:0] ADDR_DAY       = 7'h10;
  localparam logic [6:0] ADDR_HMS       = 7'h14;
  localparam logic [6:0] ADDR_ALM_DAY   = 7'h20;
  localparam logic [6:0] ADDR_ALM_HMS   = 7'h24;
  localparam logic [6:0] ADDR_ALM_EN    = 7'h28;
  localparam logic [6:0] ADDR_IRQ_EN    = 7'h2c;
  localparam logic [6:0] ADDR_IRQ_STAT  = 7'h30;

  // Top values of the time fields
  localparam logic [SIX_BITS-1:0]  SEC_MAX  = 6'd59;
  localparam logic [SIX_BITS-1:0]  MIN_MAX  = 6'd59;
  localparam logic [HOUR_BITS-1:0] HOUR_MAX = 5'd23;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  addr;
    logic [31:0] wdata;
  } rtc_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
  } rtc_out_t;

endpackage

// ===== hw/rtl/rtc_day_hms_alarm_registers_top.sv =====
// ----------------------------------------------------------------------------
// rtc_day_hms_alarm_registers_top: real-time clock with one alarm
// Bus-facing RTC: ticks, register reads and register writes, one result each.
// ----------------------------------------------------------------------------
// Each input transfer is one event: a one-second tick, a bus read or a bus
// write, and each gives exactly one result transfer carrying the read data
// (zero for ticks, writes, unmapped offsets and the unused op code) and the irq line as it stands
// after the event. The block takes one item per clock cycle while in_stall is
// low; each result is registered in the output register. All work is a
// single pass of short logic from the clock/alarm registers into the output
// register. The output side has a result register plus a one-entry skid
// register, so a new item is still taken while one result waits; in_stall
// only rises once both are full. Registers: 0x00 ctrl (busy bits [8:7],
// read only), 0x10 day, 0x14 hms (hour[20:16] minute[13:8] second[5:0]),
// 0x20 alarm day, 0x24 alarm hms, 0x28 alarm enable, 0x2c irq enable,
// 0x30 irq status (write 1 to clear). Writing day or hms sets its busy bit
// until the next tick. The alarm is compared only after a tick.
module rtc_day_hms_alarm_registers_top
  import rtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rtc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rtc_out_t out_data
);

  // Clock and register state
  logic [DAY_BITS-1:0]  day_r,       day_nxt;
  logic [HOUR_BITS-1:0] hour_r,      hour_nxt;
  logic [SIX_BITS-1:0]  min_r,       min_nxt;
  logic [SIX_BITS-1:0]  sec_r,       sec_nxt;
  logic [DAY_BITS-1:0]  alm_day_r,   alm_day_nxt;
  logic [HOUR_BITS-1:0] alm_hour_r,  alm_hour_nxt;
  logic [SIX_BITS-1:0]  alm_min_r,   alm_min_nxt;
  logic [SIX_BITS-1:0]  alm_sec_r,   alm_sec_nxt;
  logic                 alm_en_r,    alm_en_nxt;
  logic                 irq_en_r,    irq_en_nxt;
  logic                 irq_stat_r,  irq_stat_nxt;
  logic [1:0]           busy_r,      busy_nxt;

  // Output register and skid entry
  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  rtc_out_t out_data_r, out_data_nxt;
  rtc_out_t skid_data_r, skid_data_nxt;

  logic     in_xfer;
  logic     out_xfer;
  rtc_out_t result;
  logic [31:0] rdata;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;

  // Read mux: state before the event
  always_comb begin
    rdata = '0;
    unique case (in_data.addr)
      ADDR_CTRL:     rdata = {23'd0, busy_r, 7'd0};
      ADDR_DAY:      rdata = 32'(day_r);
      ADDR_HMS:      rdata = {11'd0, hour_r, 2'd0, min_r, 2'd0, sec_r};
      ADDR_ALM_DAY:  rdata = 32'(alm_day_r);
      ADDR_ALM_HMS:  rdata = {11'd0, alm_hour_r, 2'd0, alm_min_r, 2'd0, alm_sec_r};
      ADDR_ALM_EN:   rdata = {31'd0, alm_en_r};
      ADDR_IRQ_EN:   rdata = {31'd0, irq_en_r};
      ADDR_IRQ_STAT: rdata = {31'd0, irq_stat_r};
      default:       rdata = '0;
    endcase
  end

  // Next state of the clock and registers for the item on the input
  always_comb begin
    day_nxt      = day_r;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    alm_day_nxt  = alm_day_r;
    alm_hour_nxt = alm_hour_r;
    alm_min_nxt  = alm_min_r;
    alm_sec_nxt  = alm_sec_r;
    alm_en_nxt   = alm_en_r;
    irq_en_nxt   = irq_en_r;
    irq_stat_nxt = irq_stat_r;
    busy_nxt     = busy_r;
    result.rdata = '0;

    if (in_xfer) begin
      case (in_data.op)
        OP_TICK: begin
          busy_nxt = '0;
          // Out-of-range fields wrap to zero and carry, same as the top value
          if (sec_r < SEC_MAX) begin
            sec_nxt = sec_r + 1'b1;
          end else begin
            sec_nxt = '0;
            if (min_r < MIN_MAX) begin
              min_nxt = min_r + 1'b1;
            end else begin
              min_nxt = '0;
              if (hour_r < HOUR_MAX) begin
                hour_nxt = hour_r + 1'b1;
              end else begin
                hour_nxt = '0;
                day_nxt  = day_r + 1'b1;
              end
            end
          end
          if (alm_en_r && day_nxt == alm_day_r && hour_nxt == alm_hour_r &&
              min_nxt == alm_min_r && sec_nxt == alm_sec_r) begin
            irq_stat_nxt = 1'b1;
          end
        end
        OP_READ: begin
          result.rdata = rdata;
        end
        OP_WRITE: begin
          unique case (in_data.addr)
            ADDR_DAY: begin
              day_nxt     = in_data.wdata[DAY_BITS-1:0];
              busy_nxt[0] = 1'b1;
            end
            ADDR_HMS: begin
              hour_nxt    = in_data.wdata[16 +: HOUR_BITS];
              min_nxt     = in_data.wdata[8 +: SIX_BITS];
              sec_nxt     = in_data.wdata[0 +: SIX_BITS];
              busy_nxt[1] = 1'b1;
            end
            ADDR_ALM_DAY: alm_day_nxt = in_data.wdata[DAY_BITS-1:0];
            ADDR_ALM_HMS: begin
              alm_hour_nxt = in_data.wdata[16 +: HOUR_BITS];
              alm_min_nxt  = in_data.wdata[8 +: SIX_BITS];
              alm_sec_nxt  = in_data.wdata[0 +: SIX_BITS];
            end
            ADDR_ALM_EN: alm_en_nxt = in_data.wdata[0];
            ADDR_IRQ_EN: irq_en_nxt = in_data.wdata[0];
            ADDR_IRQ_STAT: begin
              if (in_data.wdata[0]) begin
                irq_stat_nxt = 1'b0;
              end
            end
            default: ;  // ctrl and unmapped offsets ignore writes
          endcase
        end
        default: ;  // unused op code
      endcase
    end

    result.irq = irq_stat_nxt & irq_en_nxt;
  end

  // Output register with skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r || out_xfer) begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r        <= '0;
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      alm_day_r    <= '0;
      alm_hour_r   <= '0;
      alm_min_r    <= '0;
      alm_sec_r    <= '0;
      alm_en_r     <= 1'b0;
      irq_en_r     <= 1'b0;
      irq_stat_r   <= 1'b0;
      busy_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      day_r        <= day_nxt;
      hour_r       <= hour_nxt;
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      alm_day_r    <= alm_day_nxt;
      alm_hour_r   <= alm_hour_nxt;
      alm_min_r    <= alm_min_nxt;
      alm_sec_r    <= alm_sec_nxt;
      alm_en_r     <= alm_en_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_stat_r   <= irq_stat_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // The skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result with the output register empty");

  // A transfer into an empty output stage shows a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !out_valid_r) |=> out_valid_r)
    else $error("accepted item produced no result");

  // A tick clears both busy bits
  a_tick_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.op == OP_TICK) |=> busy_r == 2'b00)
    else $error("busy bits survived a tick");

  // Alarm status only falls through a write-1-to-clear of the status register
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (irq_stat_r && !(in_xfer && in_data.op == OP_WRITE &&
      in_data.addr == ADDR_IRQ_STAT && in_data.wdata[0])) |=> irq_stat_r)
    else $error("alarm status cleared without a write-1-to-clear");

endmodule
